/* hw/rtl/pascal_style_tokenizer_top_defines.svh */
// Assertion macros for the tokenizer
`ifndef PASCAL_STYLE_TOKENIZER_TOP_DEFINES_SVH
`define PASCAL_STYLE_TOKENIZER_TOP_DEFINES_SVH
// implication checked every edge outside reset
`define PST_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define PST_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* hw/rtl/pst_pkg.sv */
// Package for the tokenizer: codes, widths and lookup functions
`timescale 1ns / 1ps
package pst_pkg;
  localparam int KeywordCharsDef = 9;
  localparam int PositionBitsDef = 16;
  localparam int LenW = 16;
  localparam int KwCount = 40;

  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_EOL  = 2'd1;
  localparam logic [1:0] REQ_EOI  = 2'd2;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_INT   = 3'd2;
  localparam logic [2:0] MODE_FRAC  = 3'd3;
  localparam logic [2:0] MODE_HELD  = 3'd4;
  localparam logic [2:0] MODE_BRACE = 3'd5;
  localparam logic [2:0] MODE_PAREN = 3'd6;

  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_SYMBOL  = 3'd3;
  localparam logic [2:0] KIND_GENERIC = 3'd4;
  localparam logic [2:0] KIND_EOF     = 3'd5;

  typedef logic [9*8-1:0] kw_text_t;

  // keyword text, first character in the low byte, zero padded
  function automatic kw_text_t kw_text(input int k);
    string s;
    kw_text_t t;
    case (k)
      0: s = "program";   1: s = "read";     2: s = "write";   3: s = "integer";
      4: s = "boolean";   5: s = "double";   6: s = "function"; 7: s = "procedure";
      8: s = "begin";     9: s = "end";      10: s = "and";    11: s = "array";
      12: s = "case";     13: s = "const";   14: s = "div";    15: s = "do";
      16: s = "downto";   17: s = "else";    18: s = "file";   19: s = "for";
      20: s = "goto";     21: s = "if";      22: s = "in";     23: s = "label";
      24: s = "mod";      25: s = "nil";     26: s = "not";    27: s = "of";
      28: s = "or";       29: s = "packed";  30: s = "record"; 31: s = "repeat";
      32: s = "set";      33: s = "then";    34: s = "to";     35: s = "type";
      36: s = "until";    37: s = "with";    38: s = "var";    39: s = "while";
      default: s = "";
    endcase
    t = '0;
    for (int i = 0; i < 9; i++) begin
      if (i < s.len()) t[i*8 +: 8] = s[i];
    end
    return t;
  endfunction

  function automatic int kw_len(input int k);
    kw_text_t t;
    int n;
    t = kw_text(k);
    n = 0;
    for (int i = 0; i < 9; i++) begin
      if (t[i*8 +: 8] != 8'd0) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic [4:0] single_symbol(input logic [7:0] c, output logic hit);
    logic [4:0] k;
    hit = 1'b1;
    case (c)
      "=": k = 5'd1;  "+": k = 5'd2;  "-": k = 5'd3;  "*": k = 5'd4;
      "/": k = 5'd5;  "^": k = 5'd11; ";": k = 5'd12; ",": k = 5'd13;
      "(": k = 5'd14; ")": k = 5'd15; "[": k = 5'd16; "]": k = 5'd17;
      "{": k = 5'd18; "}": k = 5'd19; ".": k = 5'd20; ":": k = 5'd21;
      "<": k = 5'd22; ">": k = 5'd23;
      default: begin
        k = 5'd0;
        hit = 1'b0;
      end
    endcase
    return k;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
endpackage

/* hw/rtl/pascal_style_tokenizer_top.sv */
// Pascal-style tokenizer top level
`timescale 1ns / 1ps
`include "pascal_style_tokenizer_top_defines.svh"
// Usage:
//   Input channel (in_valid/in_ready): one beat per source byte, end of line
//   or end of input (in_req_type). Result channel (out_valid/out_ready): one
//   token per beat; out_last marks the final token caused by an input beat.
//   An input beat gives zero, one or two tokens. The whole scan step runs in
//   the cycle the beat is accepted, between the scanner state and a four-entry
//   result queue, into which the tokens are written as the beat is accepted.
//   Throughput is one input beat per cycle; a beat that yields two tokens
//   gives two output beats, and input is taken only while the queue has
//   room for two tokens, so the queue depth sets how long stalls are absorbed.
//   Identifiers are matched against the 40 keywords in parallel compares on
//   the keyword buffer in the same cycle.
//   Reset (rst_n low, synchronous) empties the queue and returns the scanner
//   to line 1, column 1, idle. An end-of-input beat emits any pending token and
//   the EOF token and restores that scanner state. When out_ready is low, tokens
//   hold in the queue and in_ready drops once fewer than two entries are free.
module pascal_style_tokenizer_top
  import pst_pkg::*;
#(
  parameter int KEYWORD_CHARS = KeywordCharsDef,
  parameter int POSITION_BITS = PositionBitsDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic [7:0]               in_character,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_token_kind,
  output logic [5:0]               out_keyword_index,
  output logic [4:0]               out_symbol_index,
  output logic [15:0]              out_token_line,
  output logic [15:0]              out_token_column,
  output logic [15:0]              out_token_length,
  output logic                     out_last
);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam int QDepth = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  kw;
    logic [4:0]  sym;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_t;

  logic [2:0]               mode_r, mode_nxt;
  logic                     star_r, star_nxt;
  logic [7:0]               held_r, held_nxt;
  logic [7:0]               kbuf_r [KEYWORD_CHARS];
  logic [7:0]               kbuf_nxt [KEYWORD_CHARS];
  logic [LenW-1:0]          len_r, len_nxt;
  logic [POSITION_BITS-1:0] scol_r, scol_nxt, line_r, line_nxt, col_r, col_nxt;

  tok_t       q_r [QDepth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  tok_t   t0, t1;
  logic   v0, v1;
  logic   acc;

  function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

  assign in_ready = (cnt_r <= 3'(QDepth - 2));
  assign acc      = in_valid && in_ready;

  // keyword match on current buffer
  logic       kw_hit;
  logic [5:0] kw_idx;
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 6'd0;
    for (int k = KwCount - 1; k >= 0; k--) begin
      logic eq;
      kw_text_t t;
      t = kw_text(k);
      eq = (32'(len_r) == 32'(kw_len(k)));
      for (int i = 0; i < 9; i++) begin
        if (i < kw_len(k) && i < KEYWORD_CHARS) begin
          if (kbuf_r[i] != t[i*8 +: 8]) eq = 1'b0;
        end
      end
      if (eq) begin
        kw_hit = 1'b1;
        kw_idx = 6'(k);
      end
    end
  end

  always_comb begin
    tok_t flush_t, start_t, eof_t;
    logic flush_v, fl, st, consumed, hs, hit;
    logic [4:0] sidx, pidx;
    logic phit;
    logic [7:0] c;
    logic [POSITION_BITS-1:0] col_base;
    c = in_character;
    mode_nxt = mode_r; star_nxt = star_r; held_nxt = held_r;
    for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_nxt[i] = kbuf_r[i];
    len_nxt = len_r; scol_nxt = scol_r; line_nxt = line_r; col_nxt = col_r;
    v0 = 1'b0; v1 = 1'b0; t0 = '0; t1 = '0;
    flush_t = '0; start_t = '0; eof_t = '0;
    flush_v = 1'b0; fl = 1'b0; st = 1'b0; consumed = 1'b0; hs = 1'b0;

    // pending token as flush would give it
    flush_t.line = pos16(line_r);
    flush_t.col  = pos16(scol_r);
    flush_t.len  = len_r;
    case (mode_r)
      MODE_IDENT: begin
        flush_v = 1'b1;
        if (kw_hit) begin
          flush_t.kind = KIND_KEYWORD;
          flush_t.kw = kw_idx;
        end else begin
          flush_t.kind = KIND_IDENT;
        end
      end
      MODE_INT, MODE_FRAC: begin
        flush_v = 1'b1;
        flush_t.kind = KIND_NUMBER;
      end
      MODE_HELD: begin
        flush_v = 1'b1;
        flush_t.kind = KIND_SYMBOL;
        flush_t.sym = single_symbol(held_r, hs);
        flush_t.len = 16'd1;
      end
      default: flush_v = 1'b0;
    endcase

    // pair operator lookahead
    phit = 1'b1;
    if (held_r == ":" && c == "=") pidx = 5'd0;
    else if (held_r == "+" && c == "+") pidx = 5'd6;
    else if (held_r == "-" && c == "-") pidx = 5'd7;
    else if (held_r == "<" && c == ">") pidx = 5'd8;
    else if (held_r == ">" && c == "=") pidx = 5'd9;
    else if (held_r == "<" && c == "=") pidx = 5'd10;
    else begin
      pidx = 5'd0;
      phit = 1'b0;
    end
    sidx = single_symbol(c, hit);
    col_base = (col_r < PosMax) ? col_r + PosOne : col_r;

    if (acc) begin
      case (in_req_type)
        REQ_CHAR: begin
          case (mode_r)
            MODE_IDENT:
              if (is_alpha(c) || is_digit(c) || c == "_") begin
                consumed = 1'b1;
                for (int i = 0; i < KEYWORD_CHARS; i++) begin
                  if (32'(len_r) == i) kbuf_nxt[i] = c;
                end
                len_nxt = (len_r != '1) ? len_r + 1'b1 : len_r;
              end
            MODE_INT:
              if (is_digit(c) || c == ".") begin
                consumed = 1'b1;
                if (c == ".") mode_nxt = MODE_FRAC;
                len_nxt = (len_r != '1) ? len_r + 1'b1 : len_r;
              end
            MODE_FRAC:
              if (is_digit(c)) begin
                consumed = 1'b1;
                len_nxt = (len_r != '1) ? len_r + 1'b1 : len_r;
              end
            MODE_HELD:
              if (held_r == "(" && c == "*") begin
                consumed = 1'b1;
                mode_nxt = MODE_PAREN;
                star_nxt = 1'b0;
              end else if (phit) begin
                consumed = 1'b1;
                v0 = 1'b1;
                t0.kind = KIND_SYMBOL;
                t0.sym = pidx;
                t0.line = pos16(line_r);
                t0.col = pos16(scol_r);
                t0.len = 16'd2;
                mode_nxt = MODE_IDLE;
              end
            MODE_BRACE: begin
              consumed = 1'b1;
              if (c == "}") mode_nxt = MODE_IDLE;
            end
            MODE_PAREN: begin
              consumed = 1'b1;
              if (star_r && c == ")") begin
                mode_nxt = MODE_IDLE;
                star_nxt = 1'b0;
              end else begin
                star_nxt = (c == "*");
              end
            end
            default: consumed = 1'b0;
          endcase
          col_nxt = col_base;
          if (!consumed) begin
            fl = flush_v;
            mode_nxt = MODE_IDLE;
            star_nxt = 1'b0;
            start_t.line = pos16(line_r);
            start_t.col = pos16(col_r);
            start_t.len = 16'd1;
            if (is_space(c)) begin
              st = 1'b0;
            end else if (c == "{") begin
              mode_nxt = MODE_BRACE;
            end else if (is_alpha(c)) begin
              mode_nxt = MODE_IDENT;
              scol_nxt = col_r;
              kbuf_nxt[0] = c;
              len_nxt = LenW'(1);
            end else if (is_digit(c)) begin
              mode_nxt = MODE_INT;
              scol_nxt = col_r;
              len_nxt = LenW'(1);
            end else if (c == ":" || c == "+" || c == "-" || c == "<" || c == ">"
                         || c == "(") begin
              mode_nxt = MODE_HELD;
              held_nxt = c;
              scol_nxt = col_r;
            end else begin
              st = 1'b1;
              start_t.kind = hit ? KIND_SYMBOL : KIND_GENERIC;
              start_t.sym = sidx;
            end
            if (fl) begin
              v0 = 1'b1; t0 = flush_t;
              v1 = st;   t1 = start_t;
            end else begin
              v0 = st;   t0 = start_t;
            end
          end
        end
        REQ_EOL: begin
          v0 = flush_v;
          t0 = flush_t;
          mode_nxt = MODE_IDLE;
          star_nxt = 1'b0;
          line_nxt = (line_r < PosMax) ? line_r + PosOne : line_r;
          col_nxt = PosOne;
        end
        REQ_EOI: begin
          eof_t.kind = KIND_EOF;
          eof_t.col = 16'd1;
          eof_t.len = 16'd3;
          if (col_r != PosOne || mode_r != MODE_IDLE) begin
            eof_t.line = pos16((line_r < PosMax) ? line_r + PosOne : line_r);
          end else begin
            eof_t.line = pos16(line_r);
          end
          if (flush_v) begin
            v0 = 1'b1; t0 = flush_t;
            v1 = 1'b1; t1 = eof_t;
          end else begin
            v0 = 1'b1; t0 = eof_t;
          end
          mode_nxt = MODE_IDLE; star_nxt = 1'b0; held_nxt = 8'd0;
          len_nxt = '0; scol_nxt = PosOne; line_nxt = PosOne; col_nxt = PosOne;
        end
        default: v0 = 1'b0;
      endcase
    end
    if (v1) t1.last = 1'b1;
    else t0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      star_r <= 1'b0;
      held_r <= 8'd0;
      len_r  <= '0;
      scol_r <= PosOne;
      line_r <= PosOne;
      col_r  <= PosOne;
    end else begin
      mode_r <= mode_nxt;
      star_r <= star_nxt;
      held_r <= held_nxt;
      len_r  <= len_nxt;
      scol_r <= scol_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_r[i] <= kbuf_nxt[i];
  end

  // result queue
  logic pop;
  logic [1:0] push_n;
  assign pop    = out_valid && out_ready;
  assign push_n = {1'b0, v0} + {1'b0, v1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + 3'(push_n) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (v0) q_r[wp_r] <= t0;
    if (v1) q_r[wp_r + 2'd1] <= t1;
  end

  tok_t head;
  assign head              = q_r[rp_r];
  assign out_valid         = (cnt_r != 3'd0);
  assign out_token_kind    = head.kind;
  assign out_keyword_index = head.kw;
  assign out_symbol_index  = head.sym;
  assign out_token_line    = head.line;
  assign out_token_column  = head.col;
  assign out_token_length  = head.len;
  assign out_last          = head.last;

  `PST_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, cnt_r <= 3'(QDepth), "queue overflow")
  `PST_ASSERT_IMP(a_second_needs_first, clk, rst_n, v1, v0, "second token without first")
  `PST_ASSERT_NEXT(a_eoi_resets, clk, rst_n, acc && in_req_type == REQ_EOI,
                   mode_r == MODE_IDLE && line_r == PosOne, "end of input did not reset")
endmodule

/* tb/tb_top.sv */
// Self-checking tokenizer bench: directed and random text against a token predictor
`timescale 1ns / 1ps
module tb_top;
  import pst_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  kw;
    logic [4:0]  sym;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] ch;
  } src_item_t;

  localparam logic [1:0] REQ_ODD = 2'd3;
  localparam int POS_MAX = 65535;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_last;
  logic [1:0] in_req_type;
  logic [7:0] in_character;
  logic [2:0] out_token_kind;
  logic [5:0] out_keyword_index;
  logic [4:0] out_symbol_index;
  logic [15:0] out_token_line, out_token_column, out_token_length;

  pascal_style_tokenizer_top u_top (.*);

  src_item_t pending_src[$];
  token_t    expected_tokens[$];
  int errors = 0;
  int items_queued = 0;
  bit feed_done = 0;
  bit quiet_tail = 0;
  bit hold_sender = 0;
  bit long_hold_req = 0;
  bit in_fire = 0;

  // scanner copy
  logic [2:0] p_mode;
  logic       p_star;
  logic [7:0] p_held;
  logic [7:0] p_kwbuf[9];
  int p_len, p_start, p_line, p_col;
  token_t step_toks[$];

  function automatic int bump(int v, int m);
    return v < m ? v + 1 : v;
  endfunction

  function automatic logic pair_hit(logic [7:0] a, logic [7:0] b, output logic [4:0] k);
    k = 5'd0;
    if (a == ":" && b == "=") k = 5'd0;
    else if (a == "+" && b == "+") k = 5'd6;
    else if (a == "-" && b == "-") k = 5'd7;
    else if (a == "<" && b == ">") k = 5'd8;
    else if (a == ">" && b == "=") k = 5'd9;
    else if (a == "<" && b == "=") k = 5'd10;
    else return 0;
    return 1;
  endfunction

  task automatic push_tok(logic [2:0] kind, int kw, int sym, int line, int col, int len);
    token_t t;
    t.kind = kind; t.kw = 6'(kw); t.sym = 5'(sym);
    t.line = 16'(line); t.col = 16'(col); t.len = 16'(len);
    t.last = 0;
    step_toks = {step_toks, t};
  endtask

  function automatic int keyword_match();
    string s;
    for (int k = 0; k < 40; k++) begin
      s = "";
      case (k)
        0: s = "program"; 1: s = "read"; 2: s = "write"; 3: s = "integer";
        4: s = "boolean"; 5: s = "double"; 6: s = "function"; 7: s = "procedure";
        8: s = "begin"; 9: s = "end"; 10: s = "and"; 11: s = "array";
        12: s = "case"; 13: s = "const"; 14: s = "div"; 15: s = "do";
        16: s = "downto"; 17: s = "else"; 18: s = "file"; 19: s = "for";
        20: s = "goto"; 21: s = "if"; 22: s = "in"; 23: s = "label";
        24: s = "mod"; 25: s = "nil"; 26: s = "not"; 27: s = "of";
        28: s = "or"; 29: s = "packed"; 30: s = "record"; 31: s = "repeat";
        32: s = "set"; 33: s = "then"; 34: s = "to"; 35: s = "type";
        36: s = "until"; 37: s = "with"; 38: s = "var"; 39: s = "while";
        default: s = "";
      endcase
      if (s.len() == p_len) begin
        bit same;
        same = 1;
        for (int i = 0; i < s.len(); i++) if (p_kwbuf[i] != s[i]) same = 0;
        if (same) return k;
      end
    end
    return -1;
  endfunction

  task automatic scan_reset();
    p_mode = MODE_IDLE; p_star = 0; p_held = 0; p_len = 0;
    p_start = 1; p_line = 1; p_col = 1;
    for (int i = 0; i < 9; i++) p_kwbuf[i] = 0;
  endtask

  task automatic flush_pending();
    int k;
    logic hit;
    logic [4:0] s;
    if (p_mode == MODE_IDENT) begin
      k = (p_len > 9) ? -1 : keyword_match();
      if (k >= 0) push_tok(KIND_KEYWORD, k, 0, p_line, p_start, p_len);
      else push_tok(KIND_IDENT, 0, 0, p_line, p_start, p_len);
    end else if (p_mode == MODE_INT || p_mode == MODE_FRAC) begin
      push_tok(KIND_NUMBER, 0, 0, p_line, p_start, p_len);
    end else if (p_mode == MODE_HELD) begin
      s = single_symbol(p_held, hit);
      push_tok(KIND_SYMBOL, 0, int'(s), p_line, p_start, 1);
    end
    p_mode = MODE_IDLE;
    p_star = 0;
  endtask

  task automatic begin_char(logic [7:0] c);
    logic hit;
    logic [4:0] s;
    if (is_space(c)) begin
    end else if (c == "{") begin
      p_mode = MODE_BRACE;
    end else if (is_alpha(c)) begin
      p_mode = MODE_IDENT; p_start = p_col; p_kwbuf[0] = c; p_len = 1;
    end else if (is_digit(c)) begin
      p_mode = MODE_INT; p_start = p_col; p_len = 1;
    end else if (c == ":" || c == "+" || c == "-" || c == "<" || c == ">" || c == "(") begin
      p_mode = MODE_HELD; p_held = c; p_start = p_col;
    end else begin
      s = single_symbol(c, hit);
      if (hit) push_tok(KIND_SYMBOL, 0, int'(s), p_line, p_col, 1);
      else push_tok(KIND_GENERIC, 0, 0, p_line, p_col, 1);
    end
    p_col = bump(p_col, POS_MAX);
  endtask

  task automatic scan_char(logic [7:0] c);
    logic [4:0] k;
    case (p_mode)
      MODE_IDENT: if (is_alpha(c) || is_digit(c) || c == "_") begin
        if (p_len < 9) p_kwbuf[p_len] = c;
        p_len = bump(p_len, 65535); p_col = bump(p_col, POS_MAX);
        return;
      end
      MODE_INT: if (is_digit(c) || c == ".") begin
        if (c == ".") p_mode = MODE_FRAC;
        p_len = bump(p_len, 65535); p_col = bump(p_col, POS_MAX);
        return;
      end
      MODE_FRAC: if (is_digit(c)) begin
        p_len = bump(p_len, 65535); p_col = bump(p_col, POS_MAX);
        return;
      end
      MODE_HELD: begin
        if (p_held == "(" && c == "*") begin
          p_mode = MODE_PAREN; p_star = 0; p_col = bump(p_col, POS_MAX);
          return;
        end
        if (pair_hit(p_held, c, k)) begin
          push_tok(KIND_SYMBOL, 0, int'(k), p_line, p_start, 2);
          p_mode = MODE_IDLE; p_col = bump(p_col, POS_MAX);
          return;
        end
      end
      MODE_BRACE: begin
        if (c == "}") p_mode = MODE_IDLE;
        p_col = bump(p_col, POS_MAX);
        return;
      end
      MODE_PAREN: begin
        if (p_star && c == ")") begin
          p_mode = MODE_IDLE; p_star = 0;
        end else begin
          p_star = (c == "*");
        end
        p_col = bump(p_col, POS_MAX);
        return;
      end
      default: ;
    endcase
    flush_pending();
    begin_char(c);
  endtask

  task automatic close_line();
    flush_pending();
    p_line = bump(p_line, POS_MAX);
    p_col = 1;
  endtask

  task automatic predict_tokens(src_item_t it);
    step_toks.delete();
    case (it.req)
      REQ_CHAR: scan_char(it.ch);
      REQ_EOL: close_line();
      REQ_EOI: begin
        if (p_col != 1 || p_mode != MODE_IDLE) close_line();
        push_tok(KIND_EOF, 0, 0, p_line, 1, 3);
        scan_reset();
      end
      default: ;
    endcase
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1;
    foreach (step_toks[i]) expected_tokens = {expected_tokens, step_toks[i]};
  endtask

  // stimulus helpers
  task automatic put_char(logic [7:0] c);
    src_item_t it;
    it.req = REQ_CHAR; it.ch = c;
    pending_src = {pending_src, it};
    items_queued++;
  endtask
  task automatic put_req(logic [1:0] r);
    src_item_t it;
    it.req = r; it.ch = 8'($urandom);
    pending_src = {pending_src, it};
    items_queued++;
  endtask
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic string rand_word();
    string w;
    int n;
    case ($urandom_range(0, 4))
      0: w = "procedure"; 1: w = "begin"; 2: w = "while"; 3: w = "of";
      default: begin
        w = "";
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 5))
            0: w = {w, string'(8'("0" + $urandom_range(0, 9)))};
            1: w = {w, "_"};
            2: w = {w, string'(8'("A" + $urandom_range(0, 25)))};
            default: w = {w, string'(8'("a" + $urandom_range(0, 25)))};
          endcase
      end
    endcase
    return w;
  endfunction

  task automatic put_random_token();
    string ops[14] = '{":=", "<>", ">=", "<=", "++", "--", "(", "+", ";", ".", "^",
                       "(*x*)", "(*)", "{a}"};
    case ($urandom_range(0, 9))
      0, 1, 2: put_text(rand_word());
      3: put_text($sformatf("%0d", $urandom_range(0, 99999)));
      4: put_text($sformatf("%0d.%0d.", $urandom_range(0, 999), $urandom_range(0, 99)));
      5, 6: put_text(ops[$urandom_range(0, 13)]);
      7: put_char(8'($urandom));
      default: put_char(" ");
    endcase
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    bit paused_once;
    paused_once = 0;
    scan_reset();
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1;
    // directed: keywords, long ident, numbers, pairs, comments, bytes, odd request
    put_text("program x1:=3.14;"); put_req(REQ_EOL);
    put_text("procedure9abcdefg<>"); put_req(REQ_EOL);
    put_text("(*)*){ open"); put_req(REQ_EOL);
    put_char(8'd0); put_char(8'd255); put_char("_"); put_char("<"); put_req(REQ_EOL);
    put_req(REQ_ODD); put_text("a"); put_req(REQ_EOI);
    put_req(REQ_EOI);
    while (pending_src.size() > 0) @(negedge clk);
    // long receiver hold-off with the sender running
    long_hold_req = 1;
    while (items_queued < 800) begin
      if ($urandom_range(0, 15) == 0) begin
        put_req($urandom_range(0, 15) == 0 ? REQ_EOI : REQ_EOL);
      end else if ($urandom_range(0, 30) == 0) begin
        put_text("(*"); put_text(rand_word());
      end else begin
        put_random_token();
      end
      if (!paused_once && items_queued >= 400) begin
        paused_once = 1;
        while (pending_src.size() > 0) @(negedge clk);
        hold_sender = 1;
        while (expected_tokens.size() > 0 || in_valid) @(negedge clk);
        hold_sender = 0;
      end
      if (items_queued >= 650) quiet_tail = 1;
      while (pending_src.size() > 40) @(negedge clk);
    end
    put_req(REQ_EOI);
    while (pending_src.size() > 0) @(negedge clk);
    feed_done = 1;
  end

  // beat taken at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // driver
  int src_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_fire) begin
      // hold the beat
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      in_valid <= 0;
    end else if (!quiet_tail && !hold_sender && $urandom_range(0, 7) == 0) begin
      src_gap <= $urandom_range(0, 3);
      in_valid <= 0;
    end else if (!hold_sender && pending_src.size() > 0) begin
      in_valid <= 1;
      in_req_type <= pending_src[0].req;
      in_character <= pending_src[0].ch;
      void'(pending_src.pop_front());
    end else begin
      in_valid <= 0;
    end
  end

  initial begin
    in_valid = 0; in_req_type = REQ_CHAR; in_character = 0; out_ready = 0;
  end

  // receiver
  int sink_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (long_hold_req) begin
      long_hold_req <= 0;
      sink_gap <= 60;
      out_ready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready <= 0;
    end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      sink_gap <= $urandom_range(0, 3);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // monitor
  int idle_cycles = 0;
  always @(posedge clk) begin
    token_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_tokens('{in_req_type, in_character});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        got = '{out_token_kind, out_keyword_index, out_symbol_index, out_token_line,
                out_token_column, out_token_length, out_last};
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: token with none expected: actual %h", $time, got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected kind %0d kw %0d sym %0d line %0d col %0d len %0d last %0d",
                     $time, want.kind, want.kw, want.sym, want.line, want.col, want.len,
                     want.last);
            $display("%0t: actual   kind %0d kw %0d sym %0d line %0d col %0d len %0d last %0d",
                     $time, got.kind, got.kw, got.sym, got.line, got.col, got.len, got.last);
          end
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= 2000) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (feed_done && !in_valid && expected_tokens.size() == 0) begin
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
          $display("end of test: clean");
        end else begin
          $display("end of test: mismatches");
        end
        $finish;
      end
    end
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pst_pkg.sv
hw/rtl/pascal_style_tokenizer_top.sv
tb/tb_top.sv
